// File: rtl/etsr_pkg.sv
`timescale 1ns / 1ps

package etsr_pkg;

  localparam int DEF_SENSOR_WIDTH    = 640;
  localparam int DEF_SENSOR_HEIGHT   = 480;
  localparam int DEF_STEPS_PER_DECAY = 256;
  localparam int DEF_TABLE_DEPTH     = 1536;

  localparam int TIME_W      = 32;
  localparam int X_W         = 10;
  localparam int Y_W         = 9;
  localparam int SCALE_W     = 25;
  localparam int INTENSITY_W = 8;
  localparam int IN_TDATA_W  = 56;   // 51 bits of fields, zero padded to bytes
  localparam int OUT_TDATA_W = 8;

  // product of a non-negative age (31 bits) and the scale, then >> 16
  localparam int PROD_W = TIME_W - 1 + SCALE_W;
  localparam int IDX_W  = PROD_W - 16;

  localparam logic [SCALE_W-1:0] DECAY_SCALE_RESET = SCALE_W'(559);

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              fired;
    logic [TIME_W-1:0] last_time;
  } etsr_entry_t;

endpackage

// File: rtl/etsr_ram.sv
`timescale 1ns / 1ps

module etsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/etsr_decay_rom.sv
`timescale 1ns / 1ps

module etsr_decay_rom
  import etsr_pkg::*;
#(
  parameter int STEPS_PER_DECAY = DEF_STEPS_PER_DECAY,
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int AW              = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [INTENSITY_W-1:0] rd_data
);

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] STEPS64 = 64'(STEPS_PER_DECAY);

  // series terms of exp(-1/steps) in Q62; past the twelfth they are zero
  // for any steps of 16 or more
  localparam logic [63:0] T1  = Q62_ONE / STEPS64;
  localparam logic [63:0] T2  = T1  / (STEPS64 * 64'd2);
  localparam logic [63:0] T3  = T2  / (STEPS64 * 64'd3);
  localparam logic [63:0] T4  = T3  / (STEPS64 * 64'd4);
  localparam logic [63:0] T5  = T4  / (STEPS64 * 64'd5);
  localparam logic [63:0] T6  = T5  / (STEPS64 * 64'd6);
  localparam logic [63:0] T7  = T6  / (STEPS64 * 64'd7);
  localparam logic [63:0] T8  = T7  / (STEPS64 * 64'd8);
  localparam logic [63:0] T9  = T8  / (STEPS64 * 64'd9);
  localparam logic [63:0] T10 = T9  / (STEPS64 * 64'd10);
  localparam logic [63:0] T11 = T10 / (STEPS64 * 64'd11);
  localparam logic [63:0] T12 = T11 / (STEPS64 * 64'd12);
  localparam logic [63:0] RATIO = (Q62_ONE + T2 + T4 + T6 + T8 + T10 + T12)
                                - (T1 + T3 + T5 + T7 + T9 + T11);

  // (a*b) >> 62 in 32-bit halves
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll, lh, hl, hh, mid, lo, hi;
    ll  = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    lh  = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    hl  = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    hh  = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // successive powers of exp(-1/steps), scaled to 255 and rounded
  function automatic logic [TABLE_DEPTH*INTENSITY_W-1:0] build_table();
    logic [TABLE_DEPTH*INTENSITY_W-1:0] bits;
    logic [63:0] v, q, e;
    bits = '0;
    v = Q62_ONE;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      q = v >> 8;
      e = (q * 64'd255 + (64'd1 << 53)) >> 54;
      bits[i*INTENSITY_W +: INTENSITY_W] = (e > 64'd255) ? 8'd255 : e[INTENSITY_W-1:0];
      v = mul_q62(v, RATIO);
    end
    return bits;
  endfunction

  localparam logic [TABLE_DEPTH*INTENSITY_W-1:0] TABLE_BITS = build_table();

  logic [INTENSITY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (32'(rd_addr) < 32'(TABLE_DEPTH)) begin
        rd_data_r <= TABLE_BITS[rd_addr*INTENSITY_W +: INTENSITY_W];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/event_time_surface_render_top.sv
`timescale 1ns / 1ps

// Exponential-decay time surface for an event sensor.
// Input beats (in_*): tuser = mode. Mode event stores time_us at (pixel_x,
// pixel_y) and marks the pixel fired; it gives no output. Mode query gives
// one output beat: intensity = 255*exp(-age/decay) from the decay ROM, and
// has_fired. Unfired or off-sensor pixels read 0 / not fired.
// cfg_wr_en/cfg_wr_data load decay_scale (Q16 table steps per microsecond);
// write it only while no query is in flight.
// Throughput: one beat per cycle while the pipeline is not stalled, events and
// queries mixed freely. A query passes the pixel RAM read, age subtract, age*scale
// multiply, ROM read and output register stages on its way to out_tvalid.
// Reset: after rst_n, the pixel RAM is swept once, over all SENSOR_WIDTH*SENSOR_HEIGHT
// pixels (307200 by default), to clear the fired flags, with in_tready low.
// decay_scale returns to 559.
// Stall: while out_tvalid waits on out_tready and a query is in the last
// stage, the whole pipeline holds and in_tready drops; otherwise input
// keeps flowing into the empty slots.
module event_time_surface_render_top
  import etsr_pkg::*;
#(
  parameter int SENSOR_WIDTH    = DEF_SENSOR_WIDTH,
  parameter int SENSOR_HEIGHT   = DEF_SENSOR_HEIGHT,
  parameter int STEPS_PER_DECAY = DEF_STEPS_PER_DECAY,
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_x[9:0], pixel_y[18:10], time_us[50:19]
  input  logic                   in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // intensity[7:0]
  output logic                   out_tuser,  // has_fired
  input  logic                   cfg_wr_en,
  input  logic [SCALE_W-1:0]     cfg_wr_data
);

  localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int TAW    = $clog2(TABLE_DEPTH);
  localparam logic [PIX_AW-1:0] LAST_PIX = PIX_AW'(PIXELS - 1);

  // input fields
  logic [X_W-1:0]    in_x;
  logic [Y_W-1:0]    in_y;
  logic [TIME_W-1:0] in_t;
  logic              on_sensor;
  logic [PIX_AW-1:0] pix_addr;
  logic              acc;
  logic              adv;

  assign in_x = in_tdata[X_W-1:0];
  assign in_y = in_tdata[X_W+Y_W-1:X_W];
  assign in_t = in_tdata[X_W+Y_W+TIME_W-1:X_W+Y_W];

  assign on_sensor = (32'(in_x) < 32'(SENSOR_WIDTH)) && (32'(in_y) < 32'(SENSOR_HEIGHT));
  assign pix_addr = on_sensor ? PIX_AW'(PIX_AW'(in_y) * PIX_AW'(SENSOR_WIDTH) + PIX_AW'(in_x))
                              : '0;

  // config
  logic [SCALE_W-1:0] decay_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_scale_r <= DECAY_SCALE_RESET;
    end else if (cfg_wr_en) begin
      decay_scale_r <= cfg_wr_data;
    end
  end

  // clearing sweep after reset
  logic              clr_active_r;
  logic [PIX_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == LAST_PIX) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + PIX_AW'(1);
    end
  end

  // pipeline valids
  logic v1_r, v2_r, v3_r, v4_r;
  logic out_valid_r;

  assign adv       = !v4_r || !out_valid_r || out_tready;
  assign in_tready = adv && !clr_active_r;
  assign acc       = in_tvalid && in_tready;

  // pixel RAM: write on on-sensor event accept and in the clearing sweep, read on every advancing cycle
  logic              ram_we;
  logic [PIX_AW-1:0] ram_waddr;
  etsr_entry_t       ram_wdata;
  etsr_entry_t       ram_rdata;

  assign ram_we    = clr_active_r || (acc && in_tuser == MODE_EVENT && on_sensor);
  assign ram_waddr = clr_active_r ? clr_addr_r : pix_addr;
  assign ram_wdata = clr_active_r ? etsr_entry_t'('0)
                                  : etsr_entry_t'{fired: 1'b1, last_time: in_t};

  etsr_ram #(
    .WIDTH ($bits(etsr_entry_t)),
    .DEPTH (PIXELS),
    .AW    (PIX_AW)
  ) u_pix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // stage 1: RAM data arrives
  logic              inside1_r;
  logic [TIME_W-1:0] t1_r;
  // stage 2: age
  logic              fired2_r;
  logic [TIME_W-1:0] diff2_r;
  // stage 3: scaled index
  logic              fired3_r;
  logic              neg3_r;
  logic [IDX_W-1:0]  idx3_r;
  // stage 4: ROM data
  logic              fired4_r;
  logic              inr4_r;

  logic [PROD_W-1:0] prod;
  logic              idx_inr;
  logic [TAW-1:0]    rom_addr;
  logic [INTENSITY_W-1:0] rom_q;

  assign prod     = PROD_W'(diff2_r[TIME_W-2:0]) * PROD_W'(decay_scale_r);
  assign idx_inr  = neg3_r || (idx3_r < IDX_W'(TABLE_DEPTH));
  assign rom_addr = neg3_r ? '0 : idx3_r[TAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc && in_tuser == MODE_QUERY;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside1_r <= on_sensor;
      t1_r      <= in_t;
      fired2_r  <= inside1_r && ram_rdata.fired;
      diff2_r   <= t1_r - ram_rdata.last_time;
      fired3_r  <= fired2_r;
      neg3_r    <= diff2_r[TIME_W-1];
      idx3_r    <= prod[PROD_W-1:16];
      fired4_r  <= fired3_r;
      inr4_r    <= idx_inr;
    end
  end

  etsr_decay_rom #(
    .STEPS_PER_DECAY (STEPS_PER_DECAY),
    .TABLE_DEPTH     (TABLE_DEPTH),
    .AW              (TAW)
  ) u_decay_rom (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // output register
  logic [INTENSITY_W-1:0] intensity_r;
  logic                   has_fired_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && v4_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4_r) begin
      intensity_r <= (fired4_r && inr4_r) ? rom_q : '0;
      has_fired_r <= fired4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = intensity_r;
  assign out_tuser  = has_fired_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input accepted during clearing sweep");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_active_r && clr_addr_r == LAST_PIX) |=> !clr_active_r)
    else $error("clearing sweep did not end at last pixel");

  a_query_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v4_r) |=> out_valid_r)
    else $error("query in last stage did not reach output");

  a_unfired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !has_fired_r) |-> intensity_r == '0)
    else $error("unfired pixel gave nonzero intensity");

  a_rom_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && v4_r) |=> (v4_r && $stable(rom_q)))
    else $error("last stage changed while stalled");

endmodule
